### sv/orm_pkg.sv
// Shared constants and controller/datapath handshake structs for the rectangle merge block.
`default_nettype none
package orm_pkg;

  localparam int ORM_MAX_BOXES = 32;
  localparam int ORM_COORD_W   = 12;
  localparam int ORM_EDGE_W    = 13;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture accepted rectangle
    logic merge;      // compare against table and update
    logic emit_load;  // move next table entry into output register
    logic clear;      // end of list: empty table, drop overflow flag
  } orm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_last;     // captured rectangle closes the list
    logic count_zero;  // table empty
    logic emit_last;   // emit index sits on last valid entry
    logic out_free;    // output register can take a new item
  } orm_sts_t;

endpackage
`default_nettype wire

### sv/orm_if.sv
// Valid/ready channel interfaces for rectangles in and merged boxes out.
`default_nettype none
interface orm_rect_if;
  import orm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ORM_COORD_W-1:0] rect_x;
  logic [ORM_COORD_W-1:0] rect_y;
  logic [ORM_COORD_W-1:0] rect_width;
  logic [ORM_COORD_W-1:0] rect_height;
  logic                   list_end;

  modport source (output valid, rect_x, rect_y, rect_width, rect_height, list_end,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_width, rect_height, list_end,
                  output ready);
endinterface

interface orm_box_if;
  import orm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ORM_COORD_W-1:0] box_x;
  logic [ORM_COORD_W-1:0] box_y;
  logic [ORM_EDGE_W-1:0]  box_width;
  logic [ORM_EDGE_W-1:0]  box_height;
  logic                   box_final;
  logic                   dropped_flag;

  modport source (output valid, box_x, box_y, box_width, box_height, box_final,
                  dropped_flag, input ready);
  modport sink   (input valid, box_x, box_y, box_width, box_height, box_final,
                  dropped_flag, output ready);
endinterface
`default_nettype wire

### sv/overlap_rect_merge.sv
// Top level of the greedy overlapping-rectangle merge block.
//
// Usage:
//   in_rect  (sink)   one rectangle per item: x, y, width, height, and list_end
//                     on the last rectangle of a list.
//   out_box  (source) merged boxes, sent only after list_end, in table order;
//                     box_final marks the last box, dropped_flag reports that
//                     some rectangle found the table full and was discarded.
// Timing:
//   For each rectangle, the accept cycle captures it and its
//   right/bottom edges, the next cycle compares it against every table entry
//   in parallel, picks the first overlap and updates the table.
//   After list_end, boxes leave one per cycle while out_box.ready stays high,
//   from a single output register; in_ready stays low through the merge
//   cycle and the emit of every box, stall cycles included.
//   The first box is loaded from the emit state after the list_end merge.
// Stall:
//   While out_box.ready is low the output register holds its item and the
//   emit sequence waits. The final box may still sit in the output register
//   while rectangles of the next list are already accepted.
// Reset:
//   Synchronous, active low. Empties the table, clears the overflow flag and
//   the output valid; table contents are left as they are.
`default_nettype none
module overlap_rect_merge
  import orm_pkg::*;
#(
  parameter int MAX_BOXES = ORM_MAX_BOXES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  orm_rect_if.sink   in_rect,
  orm_box_if.source  out_box
);

  orm_cmd_t cmd;
  orm_sts_t sts;

  // sequencer: owns in_ready and the emit pacing
  orm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rect.valid),
    .in_ready (in_rect.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, overlap lanes and output register
  orm_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_x        (in_rect.rect_x),
    .in_y        (in_rect.rect_y),
    .in_w        (in_rect.rect_width),
    .in_h        (in_rect.rect_height),
    .in_last     (in_rect.list_end),
    .out_valid   (out_box.valid),
    .out_ready   (out_box.ready),
    .out_x       (out_box.box_x),
    .out_y       (out_box.box_y),
    .out_w       (out_box.box_width),
    .out_h       (out_box.box_height),
    .out_final   (out_box.box_final),
    .out_dropped (out_box.dropped_flag)
  );

endmodule
`default_nettype wire

### sv/orm_ctrl.sv
// Sequencer for the rectangle merge block: accept, merge, emit.
`default_nettype none
module orm_ctrl
  import orm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  orm_sts_t      sts,
  output orm_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MERGE = 3'b010,
    S_EMIT  = 3'b100
  } orm_state_t;

  orm_state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = sts.in_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.count_zero) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/orm_dp.sv
// Datapath: input register, box table with per-entry overlap lanes, output register.
`default_nettype none
module orm_dp
  import orm_pkg::*;
#(
  parameter int MAX_BOXES = ORM_MAX_BOXES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  orm_cmd_t                    cmd,
  output orm_sts_t                    sts,
  input  wire logic [ORM_COORD_W-1:0] in_x,
  input  wire logic [ORM_COORD_W-1:0] in_y,
  input  wire logic [ORM_COORD_W-1:0] in_w,
  input  wire logic [ORM_COORD_W-1:0] in_h,
  input  wire logic                   in_last,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ORM_COORD_W-1:0]      out_x,
  output logic [ORM_COORD_W-1:0]      out_y,
  output logic [ORM_EDGE_W-1:0]       out_w,
  output logic [ORM_EDGE_W-1:0]       out_h,
  output logic                        out_final,
  output logic                        out_dropped
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  // captured rectangle, kept as left/top/right/bottom
  logic [ORM_COORD_W-1:0] rx_r, ry_r;
  logic [ORM_EDGE_W-1:0]  rr_r, rb_r;
  logic                   last_r;

  // table entries, edges form
  logic [ORM_COORD_W-1:0] ent_x_r [MAX_BOXES];
  logic [ORM_COORD_W-1:0] ent_y_r [MAX_BOXES];
  logic [ORM_EDGE_W-1:0]  ent_r_r [MAX_BOXES];
  logic [ORM_EDGE_W-1:0]  ent_b_r [MAX_BOXES];

  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic [IDX_W-1:0] idx_r;

  logic [MAX_BOXES-1:0] hit_v, first_v;
  logic                 any_hit, room;

  logic                   out_valid_r, out_final_r, out_dropped_r;
  logic [ORM_COORD_W-1:0] out_x_r, out_y_r;
  logic [ORM_EDGE_W-1:0]  out_w_r, out_h_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rx_r   <= in_x;
      ry_r   <= in_y;
      rr_r   <= {1'b0, in_x} + {1'b0, in_w};
      rb_r   <= {1'b0, in_y} + {1'b0, in_h};
      last_r <= in_last;
    end
  end

  // strict overlap per lane, only valid entries take part
  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_lane
    assign hit_v[k] = (count_r > CNT_W'(k))
                   && ({1'b0, ent_x_r[k]} < rr_r) && (ent_r_r[k] > {1'b0, rx_r})
                   && (ent_b_r[k] > {1'b0, ry_r}) && ({1'b0, ent_y_r[k]} < rb_r);
  end

  assign first_v = hit_v & (-hit_v);
  assign any_hit = |hit_v;
  assign room    = (count_r < CNT_W'(MAX_BOXES));

  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_ent
    always_ff @(posedge clk) begin
      if (cmd.merge && first_v[k]) begin
        ent_x_r[k] <= (ent_x_r[k] < rx_r) ? ent_x_r[k] : rx_r;
        ent_y_r[k] <= (ent_y_r[k] < ry_r) ? ent_y_r[k] : ry_r;
        ent_r_r[k] <= (ent_r_r[k] > rr_r) ? ent_r_r[k] : rr_r;
        ent_b_r[k] <= (ent_b_r[k] > rb_r) ? ent_b_r[k] : rb_r;
      end else if (cmd.merge && !any_hit && (count_r == CNT_W'(k))) begin
        ent_x_r[k] <= rx_r;
        ent_y_r[k] <= ry_r;
        ent_r_r[k] <= rr_r;
        ent_b_r[k] <= rb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cmd.merge && !any_hit) begin
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit_load) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_x_r       <= ent_x_r[idx_r];
      out_y_r       <= ent_y_r[idx_r];
      out_w_r       <= ent_r_r[idx_r] - {1'b0, ent_x_r[idx_r]};
      out_h_r       <= ent_b_r[idx_r] - {1'b0, ent_y_r[idx_r]};
      out_final_r   <= sts.emit_last;
      out_dropped_r <= ovf_r;
    end
  end

  assign sts.in_last    = last_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.emit_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_w       = out_w_r;
  assign out_h       = out_h_r;
  assign out_final   = out_final_r;
  assign out_dropped = out_dropped_r;

endmodule
`default_nettype wire

### sv/orm_chk.sv
// Port-level checker for the rectangle merge block, bound to the top level.
`default_nettype none
module orm_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_final,
  input wire logic out_dropped
);

  // stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out item withdrawn under stall");

  // every item passes through the merge state before the next may enter
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted during merge cycle");

  // a rectangle that does not close a list frees the input again after its merge
  a_ready_returns: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> ##1 in_ready)
    else $error("input not ready after plain merge");

  // boxes of one list come back to back with a steady overflow flag
  a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final |=> out_valid && (out_dropped == $past(out_dropped)))
    else $error("gap or flag change inside box list");

endmodule

bind overlap_rect_merge orm_chk u_orm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_rect.valid),
  .in_ready    (in_rect.ready),
  .in_last     (in_rect.list_end),
  .out_valid   (out_box.valid),
  .out_ready   (out_box.ready),
  .out_final   (out_box.box_final),
  .out_dropped (out_box.dropped_flag)
);
`default_nettype wire
